[rtl/core/rbst_pkg.sv]
// Shared types and constants for the ray and box slab test.
package rbst_pkg;

  localparam int AXES = 3;
  localparam int DIV_STAGES = 35;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        t_entry;
    logic signed [31:0] t_exit;
  } res_t;

  typedef struct packed {
    logic [AXES-1:0] dzero;
    logic [AXES-1:0] in_slab;
  } axis_t;

  typedef struct packed {
    logic [AXES-1:0][32:0] num_lo;
    logic [AXES-1:0][32:0] num_hi;
    logic [AXES-1:0][31:0] dir;
    axis_t                 flags;
  } prep_t;

endpackage

[rtl/core/ray_box_slab_test.sv]
// Top level of the pipelined ray against axis-aligned box slab test.
//
// The ray channel (ray_valid, ray_stall, ray) carries one ray and one box per
// transaction; the result channel (res_valid, res_stall, res) returns hit,
// clamped entry distance and exit distance for each, in order.
// A transaction is taken whenever valid is high and stall is low.
// Throughput is one transaction per cycle: a new ray may enter every cycle while no result is stalled.
// The pipeline holds six divider lanes that each retire one quotient bit
// per stage over 32 stages, plus input, setup, sign and reduction stages.
// When res_stall holds a waiting result, the whole pipeline freezes and
// ray_stall rises in the same cycle; no transaction is lost or repeated.
// Reset clears all valid bits, so no result is presented after reset
// until new transactions arrive.
module ray_box_slab_test import rbst_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic ray_valid,
  output logic ray_stall,
  input  ray_t ray,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int LAT = DIV_STAGES + 3;

  logic en;
  logic [LAT-1:0] vld;
  prep_t prep;
  axis_t flags [DIV_STAGES];
  logic signed [AXES-1:0][31:0] ta, tb;

  assign en = ~(res_valid & res_stall);
  assign ray_stall = ~en;
  assign res_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], ray_valid};
    end
  end

  rbst_prep u_prep (.clk(clk), .en(en), .ray(ray), .prep(prep));

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk(clk), .en(en), .num(prep.num_lo[a]), .den(prep.dir[a]), .quot(ta[a])
    );
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk(clk), .en(en), .num(prep.num_hi[a]), .den(prep.dir[a]), .quot(tb[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flags[0] <= prep.flags;
      for (int s = 1; s < DIV_STAGES; s++) begin
        flags[s] <= flags[s-1];
      end
    end
  end

  rbst_merge u_merge (
    .clk(clk), .en(en), .ta(ta), .tb(tb), .flags(flags[DIV_STAGES-1]), .res(res)
  );

  a_stall: assert property (@(posedge clk) ray_stall == (res_valid && res_stall))
    else $error("ray_stall does not follow the output stall");
  a_hold: assert property (@(posedge clk) disable iff (rst) ray_stall |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

[rtl/core/rbst_prep.sv]
// Input stage: slab numerators, zero-direction and inside flags per axis.
module rbst_prep import rbst_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  ray_t  ray,
  output prep_t prep
);

  logic signed [AXES-1:0][31:0] o, d, lo, hi;
  prep_t prep_next;

  assign o  = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign d  = {ray.dir_z, ray.dir_y, ray.dir_x};
  assign lo = {ray.box_min_z, ray.box_min_y, ray.box_min_x};
  assign hi = {ray.box_max_z, ray.box_max_y, ray.box_max_x};

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prep_next.num_lo[a] = {lo[a][31], lo[a]} - {o[a][31], o[a]};
      prep_next.num_hi[a] = {hi[a][31], hi[a]} - {o[a][31], o[a]};
      prep_next.dir[a] = d[a];
      prep_next.flags.dzero[a] = (d[a] == 32'sd0);
      prep_next.flags.in_slab[a] = ($signed(o[a]) >= $signed(lo[a])) &&
                                   ($signed(o[a]) <= $signed(hi[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep <= prep_next;
    end
  end

endmodule

[rtl/core/rbst_div.sv]
// Pipelined fixed-point divider lane, one quotient bit per stage, saturated.
module rbst_div import rbst_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [32:0]        num,
  input  logic [31:0]        den,
  output logic signed [31:0] quot
);

  localparam int NW = 33 + FRAC_BITS;
  localparam int HW = NW - 32;

  logic [32:0] n_abs;
  logic [31:0] d_abs;
  logic        neg0;
  logic [NW-1:0] nsh;
  logic [31:0] upper;

  logic [31:0] rem [32];
  logic [31:0] low [32];
  logic [31:0] q   [33];
  logic [31:0] dv  [32];
  logic        neg [33];
  logic        sat [33];
  logic [32:0] rs  [32];
  logic [32:0] df  [32];

  always_ff @(posedge clk) begin
    if (en) begin
      n_abs <= num[32] ? (33'd0 - num) : num;
      d_abs <= den[31] ? (32'd0 - den) : den;
      neg0  <= num[32] ^ den[31];
    end
  end

  assign nsh = {n_abs, {FRAC_BITS{1'b0}}};
  assign upper = {{(32-HW){1'b0}}, nsh[NW-1:32]};

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      rs[k] = {rem[k], low[k][31]};
      df[k] = rs[k] - {1'b0, dv[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= upper;
      low[0] <= nsh[31:0];
      q[0]   <= '0;
      dv[0]  <= d_abs;
      neg[0] <= neg0;
      sat[0] <= (upper >= d_abs);
      for (int k = 1; k < 32; k++) begin
        rem[k] <= df[k-1][32] ? rs[k-1][31:0] : df[k-1][31:0];
        low[k] <= {low[k-1][30:0], 1'b0};
        dv[k]  <= dv[k-1];
      end
      for (int k = 1; k < 33; k++) begin
        q[k]   <= {q[k-1][30:0], ~df[k-1][32]};
        neg[k] <= neg[k-1];
        sat[k] <= sat[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[32]) begin
        if (sat[32] || (q[32] > 32'h80000000)) begin
          quot <= SAT_MIN;
        end else begin
          quot <= $signed(32'd0 - q[32]);
        end
      end else begin
        if (sat[32] || q[32][31]) begin
          quot <= SAT_MAX;
        end else begin
          quot <= $signed(q[32]);
        end
      end
    end
  end

endmodule

[rtl/core/rbst_merge.sv]
// Slab ordering and entry and exit reduction over the three axes.
module rbst_merge import rbst_pkg::*; (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [AXES-1:0][31:0] ta,
  input  logic signed [AXES-1:0][31:0] tb,
  input  axis_t                        flags,
  output res_t                         res
);

  logic signed [AXES-1:0][31:0] smin, smax;
  logic [AXES-1:0] skip;
  logic miss;
  logic signed [31:0] entry, exitv;
  res_t res_next;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        smin[a] <= ($signed(ta[a]) < $signed(tb[a])) ? ta[a] : tb[a];
        smax[a] <= ($signed(ta[a]) < $signed(tb[a])) ? tb[a] : ta[a];
      end
      skip <= flags.dzero;
      miss <= |(flags.dzero & ~flags.in_slab);
    end
  end

  always_comb begin
    entry = SAT_MIN;
    exitv = SAT_MAX;
    for (int a = 0; a < AXES; a++) begin
      if (!skip[a]) begin
        if ($signed(smin[a]) > entry) entry = smin[a];
        if ($signed(smax[a]) < exitv) exitv = smax[a];
      end
    end
    if (miss) begin
      res_next = '0;
    end else begin
      res_next.hit = (entry < exitv);
      res_next.t_entry = (entry > 32'sd0) ? entry[30:0] : 31'd0;
      res_next.t_exit = exitv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

[test/tb_top.sv]
// Testbench for the ray against axis-aligned box slab test, with a built-in predictor.
module tb_top;
  import rbst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = 38;
  localparam int N_RANDOM = 1430;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic clk;
  logic rst;
  logic ray_valid;
  logic ray_stall;
  ray_t ray;
  logic res_valid;
  logic res_stall;
  res_t res;

  ray_box_slab_test #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  typedef struct {
    ray_t r;
    logic fixed;
    res_t want;
  } row_t;

  res_t pending_hits[$];
  row_t rows[$];
  int mismatches;
  int results_seen;
  int hits_seen;
  longint cycles;
  logic feeding_done;

  function automatic longint slab_quotient(longint num, longint den);
    logic neg;
    longint n;
    longint d;
    longint q;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n <<< FRAC) / d;
    if (neg) return (q > 64'sd2147483648) ? SMIN : -q;
    return (q > SMAX) ? SMAX : q;
  endfunction

  function automatic res_t predict_box_hit(ray_t r);
    res_t o;
    longint entry;
    longint leave;
    longint org[3];
    longint dv[3];
    longint lo[3];
    longint hi[3];
    longint a;
    longint b;
    entry = SMIN;
    leave = SMAX;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dv = '{r.dir_x, r.dir_y, r.dir_z};
    lo = '{r.box_min_x, r.box_min_y, r.box_min_z};
    hi = '{r.box_max_x, r.box_max_y, r.box_max_z};
    for (int k = 0; k < 3; k++) begin
      if (dv[k] == 0) begin
        if (org[k] >= lo[k] && org[k] <= hi[k]) continue;
        o = '0;
        return o;
      end
      a = slab_quotient(lo[k] - org[k], dv[k]);
      b = slab_quotient(hi[k] - org[k], dv[k]);
      if (a > b) begin
        longint t;
        t = a;
        a = b;
        b = t;
      end
      if (a > entry) entry = a;
      if (b < leave) leave = b;
    end
    o.hit = entry < leave;
    o.t_entry = (entry > 0) ? entry[30:0] : '0;
    o.t_exit = leave[31:0];
    return o;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h00140000)) - 32'sh000a0000;
    endcase
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    logic [31:0] t;
    r.origin_x = pick_value();
    r.origin_y = pick_value();
    r.origin_z = pick_value();
    r.dir_x = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_value();
    r.dir_y = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_value();
    r.dir_z = ($urandom_range(0, 7) == 0) ? 32'h0 : pick_value();
    r.box_min_x = pick_value();
    r.box_min_y = pick_value();
    r.box_min_z = pick_value();
    r.box_max_x = pick_value();
    r.box_max_y = pick_value();
    r.box_max_z = pick_value();
    if ($urandom_range(0, 9) != 0) begin
      if (r.box_min_x > r.box_max_x) begin
        t = r.box_min_x; r.box_min_x = r.box_max_x; r.box_max_x = t;
      end
      if (r.box_min_y > r.box_max_y) begin
        t = r.box_min_y; r.box_min_y = r.box_max_y; r.box_max_y = t;
      end
      if (r.box_min_z > r.box_max_z) begin
        t = r.box_min_z; r.box_min_z = r.box_max_z; r.box_max_z = t;
      end
    end
    return r;
  endfunction

  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic add_row(ray_t r, logic fixed, res_t want);
    row_t w;
    w.r = r;
    w.fixed = fixed;
    w.want = want;
    rows.push_back(w);
  endtask

  function automatic ray_t make_ray(logic [31:0] o, logic [31:0] d, logic [31:0] lo,
                                    logic [31:0] hi);
    ray_t r;
    r = '{o, o, o, d, d, d, lo, lo, lo, hi, hi, hi};
    return r;
  endfunction

  task automatic build_directed();
    ray_t r;
    res_t miss;
    res_t inside_all;
    miss = '0;
    inside_all = '{1'b1, 31'h0, 32'sh7fffffff};
    add_row(make_ray(0, 0, 32'hffff0000, 32'h00010000), 1, inside_all);
    add_row(make_ray(32'h00020000, 0, 32'hffff0000, 32'h00010000), 1, miss);
    add_row(make_ray(0, 0, 32'h00010000, 32'hffff0000), 1, miss);
    add_row(make_ray(32'h80000000, 0, 32'h80000000, 32'h7fffffff), 1, inside_all);
    add_row(make_ray(32'h7fffffff, 0, 32'h80000000, 32'h7fffffff), 1, inside_all);
    add_row(make_ray(0, 32'h00010000, 32'h00010000, 32'h00020000), 0, miss);
    add_row(make_ray(0, 32'hffff0000, 32'hfffe0000, 32'hffff0000), 0, miss);
    add_row(make_ray(0, 32'h00000001, 32'h7fffffff, 32'h7fffffff), 0, miss);
    add_row(make_ray(32'h80000000, 32'h00000001, 32'h80000000, 32'h7fffffff), 0, miss);
    add_row(make_ray(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff), 0, miss);
    add_row(make_ray(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000), 0, miss);
    add_row(make_ray(0, 32'hffffffff, 32'h80000000, 32'h7fffffff), 0, miss);
    add_row(make_ray(32'h00050000, 32'h00010000, 0, 32'h00030000), 0, miss);
    add_row(make_ray(0, 32'h00010000, 32'h00020000, 32'h00010000), 0, miss);
    add_row(make_ray(32'hffffffff, 32'h00000003, 32'hffffffff, 32'hffffffff), 0, miss);
    r = make_ray(0, 32'h00010000, 32'h00010000, 32'h00040000);
    r.dir_y = 0;
    add_row(r, 0, miss);
    r.origin_y = 32'h00050000;
    add_row(r, 0, miss);
    r = make_ray(0, 32'h00010000, 32'hfffc0000, 32'h00040000);
    r.dir_z = 32'hfffe0000;
    r.box_min_y = 32'h00020000;
    add_row(r, 0, miss);
    r = make_ray(32'h12345678, 32'h80000001, 32'h87654321, 32'h7edcba98);
    add_row(r, 0, miss);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    res_stall = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        res_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        res_stall <= (gap_length() != 0);
      end
    end
  end

  initial begin
    int gap;
    ray_valid = 1'b0;
    ray = '0;
    feeding_done = 1'b0;
    build_directed();
    for (int i = 0; i < N_RANDOM; i++) add_row(random_ray(), 0, '0);
    @(negedge rst);
    @(negedge clk);
    foreach (rows[i]) begin
      ray_valid <= 1'b1;
      ray <= rows[i].r;
      pending_hits.push_back(rows[i].fixed ? rows[i].want : predict_box_hit(rows[i].r));
      do @(posedge clk); while (ray_stall);
      gap = (i > 400 && i < 600) ? 0 : gap_length();
      @(negedge clk);
      if (gap != 0) begin
        ray_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    ray_valid <= 1'b0;
    feeding_done = 1'b1;
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (res.hit) hits_seen++;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res);
      end else begin
        want = pending_hits.pop_front();
        if (res.hit !== want.hit || res.t_entry !== want.t_entry
            || res.t_exit !== want.t_exit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: hit %b/%b entry %h/%h exit %h/%h",
                     results_seen, want.hit, res.hit, want.t_entry, res.t_entry,
                     want.t_exit, res.t_exit);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    @(negedge rst);
    while (!(feeding_done && pending_hits.size() == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_hits.size());
      $display("simulation failed");
      $finish;
    end else begin
      repeat (LATENCY + 10) @(posedge clk);
      $display("%0d rays checked, %0d of them hitting their box, %0d mismatches",
               results_seen, hits_seen, mismatches);
      if (mismatches == 0 && pending_hits.size() == 0) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
      $finish;
    end
  end

endmodule
